// File: rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants for the serial frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 9;
  localparam int unsigned TAG_W   = 3;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_TAG     = 2'd2;

  localparam logic [BYTE_W-1:0]  HEADER_RST = 8'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 9'd256;
  localparam logic [TAG_W-1:0]   TAG_RST    = 3'd0;

  // byte count after the length byte has been taken
  localparam logic [BYTE_W-1:0] LEN_BYTE_COUNT = 8'd4;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ID   = 4'b0010,
    PH_HDR  = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [BYTE_W-1:0] byte_count;
    logic [BYTE_W-1:0] captured_id;
    logic [BYTE_W-1:0] captured_length;
  } frame_state_t;

  localparam frame_state_t STATE_RST = '{
    phase:           PH_IDLE,
    byte_count:      8'd0,
    captured_id:     8'd0,
    captured_length: 8'd0
  };

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              in_frame;
    logic [BYTE_W-1:0] position;
    logic              frame_done;
    logic              frame_abort;
    logic [BYTE_W-1:0] message_id;
    logic [BYTE_W-1:0] total_length;
    logic [TAG_W-1:0]  channel_tag;
  } frame_result_t;

endpackage

// File: rtl/sfp_step.sv
// ----------------------------------------------------------------------------
// sfp_step
// Per-byte frame state update and result formation.
// ----------------------------------------------------------------------------
module sfp_step (
  input  sfp_pkg::frame_state_t           cur,
  input  logic [sfp_pkg::BYTE_W-1:0]      byte_in,
  input  logic [sfp_pkg::BYTE_W-1:0]      header_value,
  input  logic [sfp_pkg::LIMIT_W-1:0]     length_limit,
  input  logic [sfp_pkg::TAG_W-1:0]       port_tag,
  output sfp_pkg::frame_state_t           nxt,
  output sfp_pkg::frame_result_t          res
);

  logic [sfp_pkg::BYTE_W-1:0] count_inc;
  logic                       finish;

  assign count_inc = sfp_pkg::BYTE_W'(cur.byte_count + 8'd1);

  always_comb begin
    nxt    = cur;
    finish = 1'b0;
    res    = '0;
    res.data_byte = byte_in;
    case (cur.phase)
      sfp_pkg::PH_IDLE: begin
        if (byte_in == header_value) begin
          res.in_frame        = 1'b1;
          nxt.byte_count      = 8'd1;
          nxt.captured_id     = 8'd0;
          nxt.captured_length = 8'd0;
          nxt.phase           = sfp_pkg::PH_ID;
        end
      end
      sfp_pkg::PH_ID: begin
        res.in_frame    = 1'b1;
        res.position    = cur.byte_count;
        nxt.byte_count  = count_inc;
        nxt.captured_id = byte_in;
        nxt.phase       = sfp_pkg::PH_HDR;
      end
      sfp_pkg::PH_HDR: begin
        res.in_frame   = 1'b1;
        res.position   = cur.byte_count;
        nxt.byte_count = count_inc;
        if (count_inc == sfp_pkg::LEN_BYTE_COUNT) begin
          nxt.captured_length = byte_in;
          if ({1'b0, byte_in} >= length_limit) begin
            res.frame_abort = 1'b1;
            finish          = 1'b1;
          end else begin
            nxt.phase = sfp_pkg::PH_DATA;
          end
        end
      end
      sfp_pkg::PH_DATA: begin
        res.in_frame   = 1'b1;
        res.position   = cur.byte_count;
        nxt.byte_count = count_inc;
        if (count_inc >= cur.captured_length) begin
          res.frame_done  = 1'b1;
          res.channel_tag = port_tag;
          finish          = 1'b1;
        end
      end
      default: begin
        nxt = sfp_pkg::STATE_RST;
      end
    endcase
    if (res.in_frame) begin
      res.message_id   = nxt.captured_id;
      res.total_length = nxt.captured_length;
    end
    if (finish) begin
      nxt = sfp_pkg::STATE_RST;
    end
  end

endmodule

// File: rtl/serial_frame_parser.sv
// Result: registered from the accepted byte, valid in the cycle after acceptance.
// Throughput: one byte per cycle while in_ready is high; the frame state updates in the accept cycle.
// in_ready falls only while a result is held and out_ready is low.
// Reset (synchronous, rst_n low): parser back to hunting, counters and
// captures zero, registers to header 0, limit 256, tag 0, output empty.
// ----------------------------------------------------------------------------
// serial_frame_parser
// Byte-stream frame parser with header hunt, length check and abort.
// ----------------------------------------------------------------------------
module serial_frame_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfp_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sfp_pkg::BYTE_W-1:0]         in_byte_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sfp_pkg::BYTE_W-1:0]         out_data_byte,
  output logic                               out_in_frame,
  output logic [sfp_pkg::BYTE_W-1:0]         out_position,
  output logic                               out_frame_done,
  output logic                               out_frame_abort,
  output logic [sfp_pkg::BYTE_W-1:0]         out_message_id,
  output logic [sfp_pkg::BYTE_W-1:0]         out_total_length,
  output logic [sfp_pkg::TAG_W-1:0]          out_channel_tag
);

  logic [sfp_pkg::BYTE_W-1:0]  header_value_r;
  logic [sfp_pkg::LIMIT_W-1:0] length_limit_r;
  logic [sfp_pkg::TAG_W-1:0]   port_tag_r;

  sfp_pkg::frame_state_t  state_r;
  sfp_pkg::frame_state_t  state_nxt;
  sfp_pkg::frame_result_t res_nxt;
  sfp_pkg::frame_result_t res_r;
  logic                   out_valid_r;
  logic                   in_take;

  assign in_ready = ~out_valid_r | out_ready;
  assign in_take  = in_valid & in_ready;

  sfp_step u_step (
    .cur          (state_r),
    .byte_in      (in_byte_in),
    .header_value (header_value_r),
    .length_limit (length_limit_r),
    .port_tag     (port_tag_r),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_value_r <= sfp_pkg::HEADER_RST;
      length_limit_r <= sfp_pkg::LIMIT_RST;
      port_tag_r     <= sfp_pkg::TAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sfp_pkg::CFG_HEADER_VALUE: header_value_r <= cfg_data[sfp_pkg::BYTE_W-1:0];
        sfp_pkg::CFG_LENGTH_LIMIT: length_limit_r <= cfg_data[sfp_pkg::LIMIT_W-1:0];
        sfp_pkg::CFG_PORT_TAG:     port_tag_r     <= cfg_data[sfp_pkg::TAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfp_pkg::STATE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        state_r <= state_nxt;
      end
      if (in_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = res_r.data_byte;
  assign out_in_frame     = res_r.in_frame;
  assign out_position     = res_r.position;
  assign out_frame_done   = res_r.frame_done;
  assign out_frame_abort  = res_r.frame_abort;
  assign out_message_id   = res_r.message_id;
  assign out_total_length = res_r.total_length;
  assign out_channel_tag  = res_r.channel_tag;

  // a finished or dropped frame always leaves the parser hunting
  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (res_nxt.frame_done || res_nxt.frame_abort))
      |=> (state_r.phase == sfp_pkg::PH_IDLE))
    else $error("parser not hunting after frame end");

  a_done_xor_abort: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.frame_done && res_r.frame_abort))
    else $error("frame both done and aborted");

  a_idle_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.in_frame)
      |-> (res_r.position == 8'd0 && res_r.message_id == 8'd0
           && res_r.total_length == 8'd0 && !res_r.frame_done))
    else $error("stray frame fields outside a frame");

  a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase != sfp_pkg::PH_IDLE) |-> (state_r.byte_count != 8'd0))
    else $error("zero byte count inside a frame");

endmodule
